>>> hdl/rcea_pkg.sv
// Shared types, constants and field layouts for the region color error block.
package rcea_pkg;

    localparam int QUANTUM_BITS  = 16;
    localparam int COORD_BITS    = 12;
    localparam int FRACTION_BITS = 8;
    localparam int TOTAL_BITS    = 37;
    localparam int MAX_BITS      = 25;
    localparam int SQUARE_BITS   = 2 * QUANTUM_BITS;
    localparam int SQ_BITS       = 2 * QUANTUM_BITS + 2;

    localparam int CHAN_BITS = 3;
    localparam logic [CHAN_BITS-1:0] CHAN_RESET = 3'b111;
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    localparam int IN_TDATA_BITS  = 120;
    localparam int OUT_FIELD_BITS = TOTAL_BITS + MAX_BITS + 2 * COORD_BITS;
    localparam int OUT_TDATA_BITS = 88;
    localparam int OUT_PAD_BITS   = OUT_TDATA_BITS - OUT_FIELD_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_ACCUM
    } back_state_t;

    typedef struct packed {
        logic [QUANTUM_BITS-1:0] diff_red;
        logic [QUANTUM_BITS-1:0] diff_green;
        logic [QUANTUM_BITS-1:0] diff_blue;
        logic                    enabled;
        logic [COORD_BITS-1:0]   col;
        logic [COORD_BITS-1:0]   row;
        logic                    last;
    } queue_entry_t;

    typedef struct packed {
        logic valid;
        logic full;
    } queue_status_t;

    typedef struct packed {
        logic busy;
        logic done;
    } root_status_t;

endpackage

>>> hdl/rcea_front.sv
// Front end: holds the channel mask, accepts pixel requests and forms masked channel differences.
module rcea_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [rcea_pkg::CHAN_BITS-1:0]        cfg_data,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [rcea_pkg::IN_TDATA_BITS-1:0]    s_tdata,
    input  logic                                  s_tuser,
    input  logic                                  s_tlast,
    input  rcea_pkg::queue_status_t               q_status,
    output logic                                  push,
    output rcea_pkg::queue_entry_t                push_entry
);
    import rcea_pkg::*;

    logic [CHAN_BITS-1:0]    chan_en_reg;
    logic [QUANTUM_BITS-1:0] canvas_red;
    logic [QUANTUM_BITS-1:0] canvas_green;
    logic [QUANTUM_BITS-1:0] canvas_blue;
    logic [QUANTUM_BITS-1:0] ref_red;
    logic [QUANTUM_BITS-1:0] ref_green;
    logic [QUANTUM_BITS-1:0] ref_blue;

    function automatic logic [QUANTUM_BITS-1:0] abs_diff(
        input logic [QUANTUM_BITS-1:0] a,
        input logic [QUANTUM_BITS-1:0] b,
        input logic                    en
    );
        logic [QUANTUM_BITS-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return en ? d : '0;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_en_reg <= CHAN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            chan_en_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;

    assign canvas_red   = s_tdata[0*QUANTUM_BITS +: QUANTUM_BITS];
    assign canvas_green = s_tdata[1*QUANTUM_BITS +: QUANTUM_BITS];
    assign canvas_blue  = s_tdata[2*QUANTUM_BITS +: QUANTUM_BITS];
    assign ref_red      = s_tdata[3*QUANTUM_BITS +: QUANTUM_BITS];
    assign ref_green    = s_tdata[4*QUANTUM_BITS +: QUANTUM_BITS];
    assign ref_blue     = s_tdata[5*QUANTUM_BITS +: QUANTUM_BITS];

    assign s_tready = !q_status.full;
    assign push     = s_tvalid && s_tready;

    always_comb
    begin
        push_entry.diff_red   = abs_diff(canvas_red, ref_red, chan_en_reg[CH_RED]);
        push_entry.diff_green = abs_diff(canvas_green, ref_green, chan_en_reg[CH_GREEN]);
        push_entry.diff_blue  = abs_diff(canvas_blue, ref_blue, chan_en_reg[CH_BLUE]);
        push_entry.enabled    = s_tuser;
        push_entry.col        = s_tdata[6*QUANTUM_BITS +: COORD_BITS];
        push_entry.row        = s_tdata[6*QUANTUM_BITS+COORD_BITS +: COORD_BITS];
        push_entry.last       = s_tlast;
    end

endmodule

>>> hdl/rcea_queue.sv
// Two-entry queue that decouples the front end from the back end.
module rcea_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  rcea_pkg::queue_entry_t  push_entry,
    input  logic                    pop,
    output rcea_pkg::queue_entry_t  head,
    output rcea_pkg::queue_status_t status
);
    import rcea_pkg::*;

    queue_entry_t entry_reg [2];
    logic         wr_ptr_reg;
    logic         wr_ptr_next;
    logic         rd_ptr_reg;
    logic         rd_ptr_next;
    logic [1:0]   count_reg;
    logic [1:0]   count_next;
    logic         do_push;
    logic         do_pop;

    assign status.valid = (count_reg != 2'd0);
    assign status.full  = (count_reg == 2'd2);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && status.valid;
    assign head         = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> hdl/rcea_sqrt.sv
// Iterative square root unit that produces one root bit per cycle.
module rcea_sqrt #(
    parameter  int FRACTION_BITS = rcea_pkg::FRACTION_BITS,
    localparam int RAD_BITS      = rcea_pkg::SQ_BITS + 2 * FRACTION_BITS,
    localparam int ROOT_BITS     = RAD_BITS / 2
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [RAD_BITS-1:0]    radicand,
    output logic [ROOT_BITS-1:0]   root,
    output rcea_pkg::root_status_t status
);
    import rcea_pkg::*;

    localparam int CNT_BITS = $clog2(ROOT_BITS + 1);
    localparam int REM_BITS = ROOT_BITS + 2;

    logic [RAD_BITS-1:0]  rad_reg;
    logic [RAD_BITS-1:0]  rad_next;
    logic [REM_BITS-1:0]  rem_reg;
    logic [REM_BITS-1:0]  rem_next;
    logic [ROOT_BITS-1:0] root_reg;
    logic [ROOT_BITS-1:0] root_next;
    logic [CNT_BITS-1:0]  count_reg;
    logic [CNT_BITS-1:0]  count_next;
    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [REM_BITS-1:0]  rem_shift;
    logic [REM_BITS-1:0]  trial;
    logic                 fits;

    assign rem_shift = {rem_reg[ROOT_BITS-1:0], rad_reg[RAD_BITS-1 -: 2]};
    assign trial     = {root_reg, 2'b01};
    assign fits      = (rem_shift >= trial);

    always_comb
    begin
        rad_next   = rad_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            rad_next   = radicand;
            rem_next   = '0;
            root_next  = '0;
            count_next = CNT_BITS'(ROOT_BITS);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next   = rad_reg << 2;
            rem_next   = fits ? (rem_shift - trial) : rem_shift;
            root_next  = {root_reg[ROOT_BITS-2:0], fits};
            count_next = count_reg - CNT_BITS'(1);
            if (count_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root        = root_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

>>> hdl/rcea_back.sv
// Back end: squares the differences, runs the root unit, accumulates and holds the result.
module rcea_back #(
    parameter  int FRACTION_BITS = rcea_pkg::FRACTION_BITS,
    localparam int RAD_BITS      = rcea_pkg::SQ_BITS + 2 * FRACTION_BITS,
    localparam int ROOT_BITS     = RAD_BITS / 2
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  rcea_pkg::queue_entry_t                head,
    input  rcea_pkg::queue_status_t               q_status,
    output logic                                  pop,
    output logic                                  root_start,
    output logic [RAD_BITS-1:0]                   radicand,
    input  logic [ROOT_BITS-1:0]                  root,
    input  rcea_pkg::root_status_t                root_status,
    output rcea_pkg::back_state_t                 state,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [rcea_pkg::OUT_TDATA_BITS-1:0]   m_tdata
);
    import rcea_pkg::*;

    localparam int WIDE_BITS = (ROOT_BITS > MAX_BITS) ? ROOT_BITS : MAX_BITS;
    localparam int SUM_BITS  = TOTAL_BITS + 1;

    back_state_t              state_reg;
    back_state_t              state_next;
    logic [SQUARE_BITS-1:0]   sq_red_reg;
    logic [SQUARE_BITS-1:0]   sq_green_reg;
    logic [SQUARE_BITS-1:0]   sq_blue_reg;
    logic                     enabled_reg;
    logic                     last_reg;
    logic [COORD_BITS-1:0]    col_reg;
    logic [COORD_BITS-1:0]    row_reg;
    logic [TOTAL_BITS-1:0]    total_reg;
    logic [TOTAL_BITS-1:0]    total_next;
    logic [MAX_BITS-1:0]      max_reg;
    logic [MAX_BITS-1:0]      max_next;
    logic [COORD_BITS-1:0]    best_col_reg;
    logic [COORD_BITS-1:0]    best_col_next;
    logic [COORD_BITS-1:0]    best_row_reg;
    logic [COORD_BITS-1:0]    best_row_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [TOTAL_BITS-1:0]    out_total_reg;
    logic [MAX_BITS-1:0]      out_max_reg;
    logic [COORD_BITS-1:0]    out_col_reg;
    logic [COORD_BITS-1:0]    out_row_reg;
    logic                     accum_fire;
    logic [SQ_BITS-1:0]       square_sum;
    logic [WIDE_BITS-1:0]     root_wide;
    logic [MAX_BITS-1:0]      err_val;
    logic [SUM_BITS-1:0]      total_sum;
    logic [TOTAL_BITS-1:0]    total_upd;
    logic                     new_max;
    logic [MAX_BITS-1:0]      max_upd;
    logic [COORD_BITS-1:0]    col_upd;
    logic [COORD_BITS-1:0]    row_upd;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_status.valid)
                begin
                    state_next = head.enabled ? ST_SQUARE : ST_ACCUM;
                end
            end
            ST_SQUARE:
            begin
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (root_status.done)
                begin
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM:
            begin
                if (accum_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop        = 1'b0;
        root_start = 1'b0;
        accum_fire = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                pop = q_status.valid;
            end
            ST_SQUARE:
            begin
                root_start = 1'b1;
            end
            ST_ROOT:
            begin
                pop = 1'b0;
            end
            ST_ACCUM:
            begin
                accum_fire = !(last_reg && out_valid_reg && !m_tready);
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    assign square_sum = SQ_BITS'(sq_red_reg) + SQ_BITS'(sq_green_reg) + SQ_BITS'(sq_blue_reg);
    assign radicand   = RAD_BITS'(square_sum) << (2 * FRACTION_BITS);

    always_comb
    begin
        root_wide = WIDE_BITS'(root);
        if (!enabled_reg)
        begin
            err_val = '0;
        end
        else if (root_wide > WIDE_BITS'({MAX_BITS{1'b1}}))
        begin
            err_val = '1;
        end
        else
        begin
            err_val = root_wide[MAX_BITS-1:0];
        end
        total_sum = SUM_BITS'(total_reg) + SUM_BITS'(err_val);
        total_upd = total_sum[TOTAL_BITS] ? '1 : total_sum[TOTAL_BITS-1:0];
        new_max   = (err_val > max_reg);
        max_upd   = new_max ? err_val : max_reg;
        col_upd   = new_max ? col_reg : best_col_reg;
        row_upd   = new_max ? row_reg : best_row_reg;
    end

    always_comb
    begin
        total_next     = total_reg;
        max_next       = max_reg;
        best_col_next  = best_col_reg;
        best_row_next  = best_row_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (accum_fire)
        begin
            if (last_reg)
            begin
                total_next     = '0;
                max_next       = '0;
                best_col_next  = '0;
                best_row_next  = '0;
                out_valid_next = 1'b1;
            end
            else
            begin
                total_next    = total_upd;
                max_next      = max_upd;
                best_col_next = col_upd;
                best_row_next = row_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            total_reg     <= '0;
            max_reg       <= '0;
            best_col_reg  <= '0;
            best_row_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            max_reg       <= max_next;
            best_col_reg  <= best_col_next;
            best_row_reg  <= best_row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            sq_red_reg   <= head.diff_red * head.diff_red;
            sq_green_reg <= head.diff_green * head.diff_green;
            sq_blue_reg  <= head.diff_blue * head.diff_blue;
            enabled_reg  <= head.enabled;
            last_reg     <= head.last;
            col_reg      <= head.col;
            row_reg      <= head.row;
        end
        if (accum_fire && last_reg)
        begin
            out_total_reg <= total_upd;
            out_max_reg   <= max_upd;
            out_col_reg   <= col_upd;
            out_row_reg   <= row_upd;
        end
    end

    assign state    = state_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD_BITS{1'b0}}, out_row_reg, out_col_reg, out_max_reg, out_total_reg};

endmodule

>>> hdl/region_color_error_argmax_top.sv
// Top level of the region color error block with total, maximum and its position.
//
// Channel   Dir   Handshake            Payload
// cfg       in    cfg_valid/cfg_ready  cfg_data: channel_enable (bit 0 red, 1 green, 2 blue)
// s         in    s_tvalid/s_tready    s_tdata, s_tuser (pixel_enabled), s_tlast (last_pixel)
// m         out   m_tvalid/m_tready    m_tdata: total, max, column, row
//
// An enabled pixel occupies the back end through the idle, square, root and accumulate states,
// the root unit resolving one bit per cycle; a masked pixel skips the square and root states.
// A two-entry queue keeps accepting pixels while the back end works or a result waits, until it is full.
// The last pixel of a region stalls in the back end only while an earlier result is unread.
// Reset sets the channel mask to all channels and clears the running state; no clearing pass.
module region_color_error_argmax_top #(
    parameter int FRACTION_BITS = rcea_pkg::FRACTION_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [rcea_pkg::CHAN_BITS-1:0]        cfg_data,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // canvas_red, canvas_green, canvas_blue, ref_red, ref_green, ref_blue, pixel_col, pixel_row
    input  logic [rcea_pkg::IN_TDATA_BITS-1:0]    s_tdata,
    // pixel_enabled
    input  logic                                  s_tuser,
    input  logic                                  s_tlast,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // region total, region peak, peak column, peak row, two zero bits
    output logic [rcea_pkg::OUT_TDATA_BITS-1:0]   m_tdata
);
    import rcea_pkg::*;

    localparam int RAD_BITS  = SQ_BITS + 2 * FRACTION_BITS;
    localparam int ROOT_BITS = RAD_BITS / 2;

    queue_status_t         q_status;
    queue_entry_t          push_entry;
    queue_entry_t          head;
    logic                  push;
    logic                  pop;
    logic                  root_start;
    logic [RAD_BITS-1:0]   radicand;
    logic [ROOT_BITS-1:0]  root;
    root_status_t          root_status;
    back_state_t           back_state;

    rcea_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    rcea_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    rcea_sqrt #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (radicand),
        .root     (root),
        .status   (root_status)
    );

    rcea_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_status    (q_status),
        .pop         (pop),
        .root_start  (root_start),
        .radicand    (radicand),
        .root        (root),
        .root_status (root_status),
        .state       (back_state),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

`ifndef SYNTH
    root_only_in_root_state: assert property (@(posedge clk) disable iff (!rst_n)
        (root_status.busy || root_status.done) |-> back_state == ST_ROOT)
        else $error("Root unit active outside the root state.");

    square_starts_root: assert property (@(posedge clk) disable iff (!rst_n)
        back_state == ST_SQUARE |=> root_status.busy)
        else $error("Root unit did not start after squaring.");

    result_from_accumulate: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(back_state) == ST_ACCUM)
        else $error("Result appeared without an accumulate step.");
`endif

endmodule

>>> tb/region_color_error_argmax_top_tb.sv
// Self-checking testbench for the region color error block: pixel stream in, region summaries out.
`timescale 1ns / 1ps

module region_color_error_argmax_top_tb;

    import rcea_pkg::*;

    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int PHASE_PIXELS = 120;
    localparam longint unsigned PEAK_LIMIT = (64'd1 << MAX_BITS) - 1;

    typedef struct packed {
        logic [QUANTUM_BITS-1:0] canvas_red;
        logic [QUANTUM_BITS-1:0] canvas_green;
        logic [QUANTUM_BITS-1:0] canvas_blue;
        logic [QUANTUM_BITS-1:0] ref_red;
        logic [QUANTUM_BITS-1:0] ref_green;
        logic [QUANTUM_BITS-1:0] ref_blue;
        logic                    enabled;
        logic [COORD_BITS-1:0]   col;
        logic [COORD_BITS-1:0]   row;
        logic                    last;
    } pixel_t;

    typedef struct packed {
        logic [TOTAL_BITS-1:0] total;
        logic [MAX_BITS-1:0]   peak;
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
    } region_summary_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CHAN_BITS-1:0]      cfg_data = '0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [IN_TDATA_BITS-1:0]  s_tdata = '0;
    logic                      s_tuser = 1'b0;
    logic                      s_tlast = 1'b0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_tdata;

    pixel_t          pending_pixels[$];
    region_summary_t expected_summaries[$];
    pixel_t          sent_pixel;
    pixel_t          tie_source;

    logic [CHAN_BITS-1:0]  chan_mask_model = CHAN_RESET;
    logic [TOTAL_BITS-1:0] acc_total = '0;
    logic [MAX_BITS-1:0]   acc_peak = '0;
    logic [COORD_BITS-1:0] acc_col = '0;
    logic [COORD_BITS-1:0] acc_row = '0;

    logic steady = 1'b0;
    int   fails = 0;
    int   cycles = 0;

    region_color_error_argmax_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #1 clk = ~clk;

    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned res;
        longint unsigned rem;
        longint unsigned b;
        res = 0;
        rem = v;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (rem >= res + b)
            begin
                rem = rem - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned chan_gap(input logic [QUANTUM_BITS-1:0] a,
                                                 input logic [QUANTUM_BITS-1:0] b);
        longint unsigned wa;
        longint unsigned wb;
        wa = a;
        wb = b;
        return (wa > wb) ? wa - wb : wb - wa;
    endfunction

    // The root of S shifted by twice the fraction width, rounded down, gives the fixed-point distance.
    function automatic logic [MAX_BITS-1:0] pixel_distance(input pixel_t p,
                                                           input logic [CHAN_BITS-1:0] mask);
        longint unsigned squares;
        longint unsigned d;
        longint unsigned root;
        squares = 0;
        if (mask[CH_RED])
        begin
            d = chan_gap(p.canvas_red, p.ref_red);
            squares = squares + d * d;
        end
        if (mask[CH_GREEN])
        begin
            d = chan_gap(p.canvas_green, p.ref_green);
            squares = squares + d * d;
        end
        if (mask[CH_BLUE])
        begin
            d = chan_gap(p.canvas_blue, p.ref_blue);
            squares = squares + d * d;
        end
        root = floor_root(squares << (2 * FRACTION_BITS));
        if (root > PEAK_LIMIT)
            root = PEAK_LIMIT;
        return root[MAX_BITS-1:0];
    endfunction

    task automatic account_pixel(input pixel_t p);
        logic [MAX_BITS-1:0]   err_val;
        logic [TOTAL_BITS:0]   widened;
        region_summary_t       r;
        if (p.enabled)
        begin
            err_val = pixel_distance(p, chan_mask_model);
            if (err_val > acc_peak)
            begin
                acc_peak = err_val;
                acc_col = p.col;
                acc_row = p.row;
            end
            widened = {1'b0, acc_total} + (TOTAL_BITS + 1)'(err_val);
            acc_total = widened[TOTAL_BITS] ? '1 : widened[TOTAL_BITS-1:0];
        end
        if (p.last)
        begin
            r.total = acc_total;
            r.peak = acc_peak;
            r.col = acc_col;
            r.row = acc_row;
            expected_summaries.push_back(r);
            acc_total = '0;
            acc_peak = '0;
            acc_col = '0;
            acc_row = '0;
        end
    endtask

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("%0t ns: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
        fails++;
    endtask

    task automatic check_summary(input logic [OUT_TDATA_BITS-1:0] data);
        region_summary_t got;
        region_summary_t want;
        got.total = data[TOTAL_BITS-1:0];
        got.peak = data[TOTAL_BITS +: MAX_BITS];
        got.col = data[TOTAL_BITS + MAX_BITS +: COORD_BITS];
        got.row = data[TOTAL_BITS + MAX_BITS + COORD_BITS +: COORD_BITS];
        if (expected_summaries.size() == 0)
        begin
            report_mismatch("unrequested summary total", got.total, 0);
        end
        else
        begin
            want = expected_summaries.pop_front();
            if (got.total !== want.total)
                report_mismatch("region total", got.total, want.total);
            if (got.peak !== want.peak)
                report_mismatch("region peak", got.peak, want.peak);
            if (got.col !== want.col)
                report_mismatch("max_col", got.col, want.col);
            if (got.row !== want.row)
                report_mismatch("max_row", got.row, want.row);
        end
    endtask

    // A new request is placed only once the previous one has been taken.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                account_pixel(sent_pixel);
            if (!s_tvalid || s_tready)
            begin
                if (pending_pixels.size() > 0 && (steady || $urandom_range(99) >= 6))
                begin
                    sent_pixel = pending_pixels.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {sent_pixel.row, sent_pixel.col,
                                sent_pixel.ref_blue, sent_pixel.ref_green, sent_pixel.ref_red,
                                sent_pixel.canvas_blue, sent_pixel.canvas_green,
                                sent_pixel.canvas_red};
                    s_tuser <= sent_pixel.enabled;
                    s_tlast <= sent_pixel.last;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            m_tready <= steady || ($urandom_range(99) >= 6);
            if (m_tvalid && m_tready)
                check_summary(m_tdata);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("region_color_error_argmax_top_tb: FAIL");
            $finish;
        end
    end

    function automatic pixel_t make_px(input logic [QUANTUM_BITS-1:0] cr, cg, cb, rr, rg, rb,
                                       input logic en, input logic [COORD_BITS-1:0] col, row,
                                       input logic last);
        pixel_t p;
        p.canvas_red = cr;
        p.canvas_green = cg;
        p.canvas_blue = cb;
        p.ref_red = rr;
        p.ref_green = rg;
        p.ref_blue = rb;
        p.enabled = en;
        p.col = col;
        p.row = row;
        p.last = last;
        return p;
    endfunction

    function automatic pixel_t random_pixel(input logic last, input pixel_t tie_from);
        pixel_t p;
        int style;
        style = $urandom_range(9);
        p.canvas_red = QUANTUM_BITS'($urandom);
        p.canvas_green = QUANTUM_BITS'($urandom);
        p.canvas_blue = QUANTUM_BITS'($urandom);
        p.ref_red = QUANTUM_BITS'($urandom);
        p.ref_green = QUANTUM_BITS'($urandom);
        p.ref_blue = QUANTUM_BITS'($urandom);
        case (style)
            4, 5:
            begin
                p.ref_red = p.canvas_red + QUANTUM_BITS'($urandom_range(6)) - 16'd3;
                p.ref_green = p.canvas_green + QUANTUM_BITS'($urandom_range(6)) - 16'd3;
                p.ref_blue = p.canvas_blue + QUANTUM_BITS'($urandom_range(6)) - 16'd3;
            end
            6:
            begin
                p.ref_red = p.canvas_red;
                p.ref_green = p.canvas_green;
                p.ref_blue = p.canvas_blue;
            end
            7:
            begin
                p.canvas_red = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                p.canvas_green = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                p.canvas_blue = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                p.ref_red = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                p.ref_green = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                p.ref_blue = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            end
            8:
            begin
                p.canvas_red = tie_from.canvas_red;
                p.canvas_green = tie_from.canvas_green;
                p.canvas_blue = tie_from.canvas_blue;
                p.ref_red = tie_from.ref_red;
                p.ref_green = tie_from.ref_green;
                p.ref_blue = tie_from.ref_blue;
            end
            default:
            begin
            end
        endcase
        p.enabled = $urandom_range(99) < 85;
        p.col = COORD_BITS'($urandom);
        p.row = COORD_BITS'($urandom);
        p.last = last;
        return p;
    endfunction

    task automatic add_region(input int len);
        pixel_t p;
        for (int i = 0; i < len; i++)
        begin
            p = random_pixel(i == len - 1, tie_source);
            if ($urandom_range(2) == 0)
                tie_source = p;
            pending_pixels.push_back(p);
        end
    endtask

    task automatic wait_for_drain();
        while (pending_pixels.size() != 0 || s_tvalid || expected_summaries.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_channel_mask(input logic [CHAN_BITS-1:0] mask);
        wait_for_drain();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= mask;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        chan_mask_model = mask;
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [CHAN_BITS-1:0] phase_masks [9];
        int queued;
        int len;
        phase_masks = '{3'd0, 3'd1, 3'd2, 3'd4, 3'd3, 3'd5, 3'd6, 3'd7, 3'd0};
        phase_masks[8] = CHAN_BITS'($urandom_range(7));
        tie_source = make_px(0, 0, 0, 0, 0, 0, 1'b1, 0, 0, 1'b0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Zero distance keeps coordinates at zero; ties keep the first maximum.
        pending_pixels.push_back(make_px(0, 0, 0, 0, 0, 0, 1'b1, 12'hFFF, 12'hFFF, 1'b0));
        pending_pixels.push_back(make_px(16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0,
                                         1'b1, 12'hFFF, 12'h000, 1'b0));
        pending_pixels.push_back(make_px(0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                         1'b1, 12'h001, 12'h002, 1'b0));
        pending_pixels.push_back(make_px(16'hFFFF, 0, 16'hFFFF, 0, 16'hFFFF, 0,
                                         1'b0, 12'h005, 12'h005, 1'b1));
        pending_pixels.push_back(make_px(0, 0, 0, 0, 0, 0, 1'b1, 12'h800, 12'h800, 1'b1));
        pending_pixels.push_back(make_px(16'h1234, 16'hFFFF, 0, 0, 16'h4321, 16'hFFFF,
                                         1'b0, 12'h0AA, 12'h055, 1'b1));
        pending_pixels.push_back(make_px(3, 4, 0, 0, 0, 0, 1'b1, 12'h007, 12'h009, 1'b1));
        pending_pixels.push_back(make_px(1, 1, 1, 0, 0, 0, 1'b1, 12'h010, 12'h020, 1'b0));
        pending_pixels.push_back(make_px(0, 0, 0, 1, 1, 2, 1'b1, 12'h030, 12'h040, 1'b0));
        pending_pixels.push_back(make_px(2, 0, 0, 0, 1, 1, 1'b1, 12'h050, 12'h060, 1'b0));
        pending_pixels.push_back(make_px(0, 0, 0, 0, 0, 0, 1'b1, 12'h070, 12'h080, 1'b1));
        pending_pixels.push_back(make_px(16'hFFFF, 16'h8000, 16'h0001, 0, 16'h8001, 16'hFFFE,
                                         1'b1, 12'hABC, 12'h543, 1'b1));

        foreach (phase_masks[i])
        begin
            set_channel_mask(phase_masks[i]);
            steady <= (i == 7);
            queued = 0;
            while (queued < PHASE_PIXELS)
            begin
                len = ($urandom_range(99) < 90) ? $urandom_range(1, 12) : $urandom_range(13, 48);
                add_region(len);
                queued += len;
            end
        end

        wait_for_drain();
        if (fails == 0)
            $display("region_color_error_argmax_top_tb: PASS");
        else
            $display("region_color_error_argmax_top_tb: FAIL");
        $finish;
    end

endmodule
